>>> rtl/core/fdrpt_pkg.sv
`timescale 1ns / 1ps

package fdrpt_pkg;

  localparam int unsigned PValW    = 16;
  localparam int unsigned IdxOutW  = 6;
  localparam logic [PValW-1:0] AlphaReset = 16'd3277;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ_I,
    ST_COUNT,
    ST_TEST_MUL,
    ST_TEST_CMP,
    ST_READ_OUT,
    ST_EMIT
  } fdrpt_state_e;

endpackage

>>> rtl/core/fdrpt_in_if.sv
`timescale 1ns / 1ps

interface fdrpt_in_if import fdrpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PValW-1:0] p_value;
  logic             last_in;

  modport source (output valid, output p_value, output last_in, input ready);
  modport sink (input valid, input p_value, input last_in, output ready);
endinterface

>>> rtl/core/fdrpt_out_if.sv
`timescale 1ns / 1ps

interface fdrpt_out_if import fdrpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IdxOutW-1:0] element_index;
  logic               detected;
  logic [PValW-1:0]   cutoff;
  logic               last_out;

  modport source (
    output valid, output element_index, output detected, output cutoff, output last_out,
    input ready
  );
  modport sink (
    input valid, input element_index, input detected, input cutoff, input last_out,
    output ready
  );
endinterface

>>> rtl/core/fdrpt_store.sv
`timescale 1ns / 1ps

module fdrpt_store import fdrpt_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [PValW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [PValW-1:0] rdata_o
);

  logic [PValW-1:0] mem_q [Depth];
  logic [PValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/fdrpt_test_unit.sv
`timescale 1ns / 1ps

module fdrpt_test_unit import fdrpt_pkg::*; #(
  parameter int unsigned CntW = 7
) (
  input  logic             clk_i,
  input  logic [PValW-1:0] p_i,
  input  logic [CntW-1:0]  n_i,
  input  logic [PValW-1:0] alpha_i,
  input  logic [CntW-1:0]  rank_i,
  output logic             pass_o
);

  localparam int unsigned ProdW = PValW + CntW;

  logic [ProdW-1:0] lhs_q;
  logic [ProdW-1:0] rhs_q;

  // Both sides are exact products, so the rank test needs no rounding.
  always_ff @(posedge clk_i) begin
    lhs_q <= ProdW'(p_i) * ProdW'(n_i);
    rhs_q <= ProdW'(alpha_i) * ProdW'(rank_i);
  end

  assign pass_o = (lhs_q <= rhs_q);

endmodule

>>> rtl/core/fdr_pvalue_threshold_unit.sv
`timescale 1ns / 1ps

// Loading takes one cycle per word; a set of N words is then evaluated by one shared
// compare and multiply unit, each element being ranked by a full pass over the store at
// one read per cycle. The N results then follow, each through ST_READ_OUT and ST_EMIT,
// as the sink takes them; no new set is accepted until the last result has been emitted.
// Reset clears the sequencer, the loaded count and the output valid, and sets alpha to
// 3277; the p-value store is not cleared.
module fdr_pvalue_threshold_unit import fdrpt_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PValW-1:0] cfg_data_i,
  fdrpt_in_if.sink         in_i,
  fdrpt_out_if.source      out_o
);

  localparam int unsigned IdxW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);

  fdrpt_state_e state_q, state_d;

  logic [PValW-1:0]   alpha_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    i_q;
  logic [CntW-1:0]    j_q;
  logic [CntW-1:0]    k_q;
  logic [CntW-1:0]    cnt_q;
  logic               pend_q;
  logic [PValW-1:0]   pi_q;
  logic [PValW-1:0]   cutoff_q;
  logic               passed_q;

  logic               out_valid_q;
  logic [IdxOutW-1:0] out_index_q;
  logic               out_det_q;
  logic [PValW-1:0]   out_cutoff_q;
  logic               out_last_q;

  logic               in_accept;
  logic               mem_we;
  logic [IdxW-1:0]    mem_raddr;
  logic [PValW-1:0]   rdata;
  logic               out_load;
  logic               rank_pass;
  logic               i_last;
  logic               k_last;
  logic               room;

  assign room      = (count_q < CntW'(MAX_ELEMENTS));
  assign in_accept = in_i.valid && in_i.ready;
  assign i_last    = (i_q == count_q - CntW'(1));
  assign k_last    = (k_q == count_q - CntW'(1));

  fdrpt_store #(
    .Depth (MAX_ELEMENTS),
    .AddrW (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (in_i.p_value),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  fdrpt_test_unit #(
    .CntW (CntW)
  ) u_test (
    .clk_i   (clk_i),
    .p_i     (pi_q),
    .n_i     (count_q),
    .alpha_i (alpha_q),
    .rank_i  (cnt_q),
    .pass_o  (rank_pass)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_accept && in_i.last_in) begin
          state_d = ST_READ_I;
        end
      end
      ST_READ_I: begin
        state_d = ST_COUNT;
      end
      ST_COUNT: begin
        if (j_q == count_q) begin
          state_d = ST_TEST_MUL;
        end
      end
      ST_TEST_MUL: begin
        state_d = ST_TEST_CMP;
      end
      ST_TEST_CMP: begin
        state_d = i_last ? ST_READ_OUT : ST_READ_I;
      end
      ST_READ_OUT: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = k_last ? ST_LOAD : ST_READ_OUT;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    mem_raddr  = '0;
    out_load   = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_i.ready = 1'b1;
      end
      ST_READ_I: begin
        mem_raddr = i_q[IdxW-1:0];
      end
      ST_COUNT: begin
        mem_raddr = j_q[IdxW-1:0];
      end
      ST_READ_OUT: begin
        mem_raddr = k_q[IdxW-1:0];
      end
      ST_EMIT: begin
        mem_raddr = k_q[IdxW-1:0];
        out_load  = !out_valid_q || out_o.ready;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  assign mem_we = in_accept && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaReset;
    end else if (cfg_we_i) begin
      alpha_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      passed_q <= 1'b0;
      cutoff_q <= '0;
      pi_q     <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (mem_we) begin
            count_q <= count_q + CntW'(1);
          end
          if (in_accept && in_i.last_in) begin
            i_q      <= '0;
            passed_q <= 1'b0;
            cutoff_q <= '0;
          end
        end
        ST_READ_I: begin
          j_q    <= '0;
          cnt_q  <= '0;
          pend_q <= 1'b0;
        end
        ST_COUNT: begin
          if (j_q == '0) begin
            pi_q <= rdata;
          end
          if (pend_q && (rdata <= pi_q)) begin
            cnt_q <= cnt_q + CntW'(1);
          end
          pend_q <= (j_q != count_q);
          if (j_q != count_q) begin
            j_q <= j_q + CntW'(1);
          end
        end
        ST_TEST_CMP: begin
          if (rank_pass && (!passed_q || (pi_q > cutoff_q))) begin
            cutoff_q <= pi_q;
            passed_q <= 1'b1;
          end
          i_q <= i_q + CntW'(1);
          if (i_last) begin
            k_q <= '0;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            k_q <= k_q + CntW'(1);
            if (k_last) begin
              count_q <= '0;
            end
          end
        end
        default: begin
          pend_q <= pend_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q  <= IdxOutW'(k_q);
      out_det_q    <= passed_q && (rdata <= cutoff_q);
      out_cutoff_q <= cutoff_q;
      out_last_q   <= k_last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.element_index = out_index_q;
  assign out_o.detected      = out_det_q;
  assign out_o.cutoff        = out_cutoff_q;
  assign out_o.last_out      = out_last_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb import fdrpt_pkg::*; ();

  localparam int unsigned MaxElems   = 64;
  localparam int unsigned StallLimit = 30000;
  localparam int unsigned LongHold   = 400;

  typedef struct packed {
    logic [IdxOutW-1:0] element_index;
    logic               detected;
    logic [PValW-1:0]   cutoff;
    logic               last_out;
  } verdict_t;

  class bh_checker;
    logic [PValW-1:0] pvals[MaxElems];
    int unsigned      n_loaded;
    logic [PValW-1:0] alpha;
    verdict_t         pending_verdicts[$];
    int unsigned      errors;

    function new();
      n_loaded = 0;
      alpha    = AlphaReset;
      errors   = 0;
    endfunction

    function void set_alpha(input logic [PValW-1:0] a);
      alpha = a;
    endfunction

    // The best rank of a value is the count of words at or below it, so no sort is needed.
    function void note_word(input logic [PValW-1:0] p, input logic lst);
      logic [PValW-1:0] cut;
      bit               passed;
      int unsigned      le;
      verdict_t         v;
      if (n_loaded < MaxElems) begin
        pvals[n_loaded] = p;
        n_loaded++;
      end
      if (!lst) return;
      cut    = '0;
      passed = 1'b0;
      for (int unsigned i = 0; i < n_loaded; i++) begin
        le = 0;
        for (int unsigned j = 0; j < n_loaded; j++) begin
          if (pvals[j] <= pvals[i]) le++;
        end
        if (64'(pvals[i]) * 64'(n_loaded) <= 64'(alpha) * 64'(le)) begin
          if (!passed || pvals[i] > cut) cut = pvals[i];
          passed = 1'b1;
        end
      end
      for (int unsigned i = 0; i < n_loaded; i++) begin
        v.element_index = i[IdxOutW-1:0];
        v.detected      = passed && (pvals[i] <= cut);
        v.cutoff        = cut;
        v.last_out      = (i == n_loaded - 1);
        pending_verdicts.push_back(v);
      end
      n_loaded = 0;
    endfunction

    function void check_verdict(input logic [IdxOutW-1:0] idx, input logic det,
                                input logic [PValW-1:0] cut, input logic lst);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual index %0d detected %b cutoff %0d",
                 $time, idx, det, cut);
        errors++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (idx !== v.element_index) begin
        $display("%0t: element_index expected %0d actual %0d", $time, v.element_index, idx);
        errors++;
      end
      if (det !== v.detected) begin
        $display("%0t: detected expected %b actual %b (index %0d)", $time, v.detected, det,
                 v.element_index);
        errors++;
      end
      if (cut !== v.cutoff) begin
        $display("%0t: cutoff expected %0d actual %0d (index %0d)", $time, v.cutoff, cut,
                 v.element_index);
        errors++;
      end
      if (lst !== v.last_out) begin
        $display("%0t: last_out expected %b actual %b (index %0d)", $time, v.last_out, lst,
                 v.element_index);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [PValW-1:0] cfg_data_i;

  fdrpt_in_if  in_if ();
  fdrpt_out_if out_if ();

  fdr_pvalue_threshold_unit #(
    .MAX_ELEMENTS(MaxElems)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  bh_checker   verdicts_chk = new();
  int unsigned words_sent = 0;
  int unsigned gap_pct = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        verdicts_chk.check_verdict(out_if.element_index, out_if.detected, out_if.cutoff,
                                   out_if.last_out);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LongHold;
      end else if (hold == 0 && !calm && $urandom_range(0, 99) < gap_pct) begin
        hold = $urandom_range(1, 13);
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [PValW-1:0] p, input logic lst);
    if (words_sent >= 380) calm = 1'b1;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.p_value <= p;
    in_if.last_in <= lst;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    verdicts_chk.note_word(p, lst);
    words_sent++;
  endtask

  task automatic send_set(input int unsigned n);
    logic [PValW-1:0] p;
    logic [PValW-1:0] prev;
    int unsigned      r;
    prev = '0;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) p = PValW'($urandom_range(0, verdicts_chk.alpha));
      else if (r < 45) p = '0;
      else if (r < 50) p = '1;
      else if (r < 60) p = prev;
      else if (r < 70) p = PValW'($urandom_range(0, verdicts_chk.alpha / 4));
      else p = PValW'($urandom);
      send_word(p, i == n - 1);
      prev = p;
    end
  endtask

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 88) return $urandom_range(9, 24);
    if (r < 95) return $urandom_range(25, 40);
    if (r < 98) return MaxElems;
    return $urandom_range(MaxElems + 1, MaxElems + 4);
  endfunction

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (verdicts_chk.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_alpha(input logic [PValW-1:0] a);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= a;
    @(posedge clk_i);
    verdicts_chk.set_alpha(a);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      phase_start;
    logic [PValW-1:0] a;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.p_value <= '0;
    in_if.last_in <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets, first at the reset alpha: a lone zero, a lone full-scale word, a mix.
    gap_pct = 20;
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'd3277, 1'b0);
    send_word(16'd1638, 1'b1);
    wait_drained();
    write_alpha(16'h0000);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0001, 1'b1);
    wait_drained();
    write_alpha(16'hFFFF);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'd12345, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'd40000, 1'b1);
    wait_drained();
    write_alpha(16'h8000);
    send_word(16'h5555, 1'b0);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h0001, 1'b1);

    phase = 0;
    while (words_sent < 440) begin
      wait_drained();
      case (phase % 6)
        0: a = 16'hFFFF;
        1: a = 16'h0000;
        2: a = AlphaReset;
        3: a = PValW'($urandom);
        4: a = PValW'($urandom_range(1, 6000));
        default: a = PValW'($urandom_range(6000, 40000));
      endcase
      write_alpha(a);
      case (phase % 3)
        0: gap_pct = 25;
        1: gap_pct = 0;
        default: gap_pct = 10;
      endcase
      phase_start = words_sent;
      // A short set is evaluated quickly, so its results meet the long hold on the sink.
      if (phase == 1) begin
        long_hold_req = 1'b1;
        send_set(4);
      end
      // Overflowing set: words past the store depth are dropped, the last mark still counts.
      if (phase == 2) send_set(MaxElems + 2);
      if (phase == 3) send_set(MaxElems);
      while (words_sent - phase_start < 60) send_set(pick_size());
      phase++;
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (verdicts_chk.errors == 0 && verdicts_chk.pending_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/fdrpt_pkg.sv
rtl/core/fdrpt_in_if.sv
rtl/core/fdrpt_out_if.sv
rtl/core/fdrpt_store.sv
rtl/core/fdrpt_test_unit.sv
rtl/core/fdr_pvalue_threshold_unit.sv
tb/tb.sv
